// File: hdl/ccm_pkg.sv
package ccm_pkg;

  localparam int SMP_W           = 16;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MUL_W           = SMP_W + 1;
  localparam int PROD_W          = 2 * MUL_W;
  localparam int SUM_W           = PROD_W + 1;
  localparam int ACC_W           = 43;
  localparam int MAG_W           = 42;
  localparam int ROOT_W          = 44;
  localparam int RAD_W           = 2 * ROOT_W;
  localparam int REM_W           = ROOT_W + 3;
  localparam int SQ_STEPS        = ACC_W;
  localparam int RT_STEPS        = ROOT_W;
  localparam int CNT_W           = 6;
  localparam int IN_TDATA_W      = 4 * SMP_W;
  localparam int OUT_TDATA_W     = 48;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_FLUSH,
    ST_LOAD,
    ST_SQUARE,
    ST_ROOT,
    ST_DONE
  } ccm_state_t;

  typedef struct packed {
    logic in_load;
    logic mag_load;
    logic sq_step;
    logic rt_step;
    logic out_load;
  } ccm_cmd_t;

  typedef struct packed {
    logic acc_last;
    logic out_free;
  } ccm_sts_t;

endpackage

// File: hdl/ccm_ctrl.sv
module ccm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  input  ccm_pkg::ccm_sts_t sts,
  output ccm_pkg::ccm_cmd_t cmd
);
  import ccm_pkg::*;

  ccm_state_t       state_r;
  ccm_state_t       state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_RUN: begin
        in_tready   = 1'b1;
        cmd.in_load = in_tvalid;
        if (in_tvalid && in_tlast) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (sts.acc_last) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.mag_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.sq_step = 1'b1;
        if (cnt_r == CNT_W'(SQ_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_ROOT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_ROOT: begin
        cmd.rt_step = 1'b1;
        if (cnt_r == CNT_W'(RT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

endmodule

// File: hdl/ccm_dp.sv
module ccm_dp #(
  parameter int SAMPLE_BITS = ccm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [ccm_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                              in_tlast,
  input  ccm_pkg::ccm_cmd_t                 cmd,
  output ccm_pkg::ccm_sts_t                 sts,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ccm_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import ccm_pkg::*;

  localparam bit SIGNED_SMP = (SAMPLE_BITS <= SMP_W);
  localparam int SIGN_IDX   = SIGNED_SMP ? SAMPLE_BITS - 1 : SMP_W - 1;

  function automatic logic signed [MUL_W-1:0] sext(input logic [SMP_W-1:0] f);
    logic [MUL_W-1:0] v;
    for (int i = 0; i < SMP_W; i++) begin
      if (i < SAMPLE_BITS) begin
        v[i] = f[i];
      end else begin
        v[i] = SIGNED_SMP ? f[SIGN_IDX] : 1'b0;
      end
    end
    v[SMP_W] = SIGNED_SMP ? f[SIGN_IDX] : 1'b0;
    return signed'(v);
  endfunction

  logic                      s1_vld_r, s1_last_r;
  logic signed [MUL_W-1:0]   ar_r, ai_r, br_r, bi_r;
  logic                      s2_vld_r, s2_last_r;
  logic signed [PROD_W-1:0]  p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  logic                      s3_vld_r, s3_last_r;
  logic signed [SUM_W-1:0]   pr_r, pi_r;
  logic signed [ACC_W-1:0]   acc_re_r, acc_im_r;
  logic signed [ACC_W-1:0]   acc_re_nxt, acc_im_nxt;
  logic signed [ACC_W:0]     sum_re, sum_im;
  logic [ACC_W-1:0]          abs_re_r, abs_im_r;
  logic [ACC_W-1:0]          sh_re_r, sh_im_r;
  logic [RAD_W-1:0]          rad_r;
  logic [ACC_W:0]            sq_add;
  logic [ROOT_W-1:0]         root_r;
  logic [REM_W-1:0]          rem_r;
  logic [REM_W-1:0]          rem_sh;
  logic [REM_W-1:0]          trial;
  logic                      out_vld_r;
  logic [MAG_W-1:0]          mag_r;

  function automatic logic signed [ACC_W-1:0] sat(input logic signed [ACC_W:0] s);
    logic signed [ACC_W-1:0] r;
    if (s[ACC_W] != s[ACC_W-1]) begin
      r = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      r = s[ACC_W-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      s1_last_r <= 1'b0;
      s2_last_r <= 1'b0;
      s3_last_r <= 1'b0;
      acc_re_r  <= '0;
      acc_im_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= cmd.in_load;
      s1_last_r <= cmd.in_load & in_tlast;
      s2_vld_r  <= s1_vld_r;
      s2_last_r <= s1_last_r;
      s3_vld_r  <= s2_vld_r;
      s3_last_r <= s2_last_r;
      acc_re_r  <= acc_re_nxt;
      acc_im_r  <= acc_im_nxt;
      if (cmd.out_load) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      ar_r <= sext(in_tdata[SMP_W-1:0]);
      ai_r <= sext(in_tdata[2*SMP_W-1:SMP_W]);
      br_r <= sext(in_tdata[3*SMP_W-1:2*SMP_W]);
      bi_r <= sext(in_tdata[4*SMP_W-1:3*SMP_W]);
    end
    p_rr_r <= ar_r * br_r;
    p_ii_r <= ai_r * bi_r;
    p_ri_r <= ar_r * bi_r;
    p_ir_r <= ai_r * br_r;
    pr_r   <= SUM_W'(p_rr_r) - SUM_W'(p_ii_r);
    pi_r   <= SUM_W'(p_ri_r) + SUM_W'(p_ir_r);
  end

  assign sum_re = (ACC_W+1)'(acc_re_r) + (ACC_W+1)'(pr_r);
  assign sum_im = (ACC_W+1)'(acc_im_r) + (ACC_W+1)'(pi_r);

  always_comb begin
    acc_re_nxt = acc_re_r;
    acc_im_nxt = acc_im_r;
    if (cmd.mag_load) begin
      acc_re_nxt = '0;
      acc_im_nxt = '0;
    end else if (s3_vld_r) begin
      acc_re_nxt = sat(sum_re);
      acc_im_nxt = sat(sum_im);
    end
  end

  assign sq_add = (sh_re_r[ACC_W-1] ? {1'b0, abs_re_r} : '0)
                + (sh_im_r[ACC_W-1] ? {1'b0, abs_im_r} : '0);

  assign rem_sh = {rem_r[REM_W-3:0], rad_r[RAD_W-1:RAD_W-2]};
  assign trial  = {1'b0, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.mag_load) begin
      abs_re_r <= acc_re_r[ACC_W-1] ? ACC_W'(~acc_re_r + 1'b1) : ACC_W'(acc_re_r);
      abs_im_r <= acc_im_r[ACC_W-1] ? ACC_W'(~acc_im_r + 1'b1) : ACC_W'(acc_im_r);
      sh_re_r  <= acc_re_r[ACC_W-1] ? ACC_W'(~acc_re_r + 1'b1) : ACC_W'(acc_re_r);
      sh_im_r  <= acc_im_r[ACC_W-1] ? ACC_W'(~acc_im_r + 1'b1) : ACC_W'(acc_im_r);
      rad_r    <= '0;
      root_r   <= '0;
      rem_r    <= '0;
    end else if (cmd.sq_step) begin
      sh_re_r <= {sh_re_r[ACC_W-2:0], 1'b0};
      sh_im_r <= {sh_im_r[ACC_W-2:0], 1'b0};
      rad_r   <= {rad_r[RAD_W-2:0], 1'b0} + RAD_W'(sq_add);
    end else if (cmd.rt_step) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      mag_r <= (|root_r[ROOT_W-1:MAG_W]) ? {MAG_W{1'b1}} : root_r[MAG_W-1:0];
    end
  end

  assign sts.acc_last = s3_vld_r & s3_last_r;
  assign sts.out_free = ~out_vld_r | out_tready;
  assign out_tvalid   = out_vld_r;
  assign out_tdata    = {{(OUT_TDATA_W-MAG_W){1'b0}}, mag_r};

endmodule

// File: hdl/complex_correlation_magnitude.sv
// Pair transactions are accepted one per cycle, back to back, until one with tlast.
// After the tlast transaction, the result passes through these steps in order: the
// multiply-accumulate pipeline drains (operand, product and sum registers), the absolute
// values are taken, 43 squaring steps and 44 square root steps run, and the output
// register is loaded, which waits while a result is stalled. Input is not ready meanwhile.
// Synchronous active-low reset clears the accumulators, the valid bits and the controller.
module complex_correlation_magnitude #(
  parameter int SAMPLE_BITS = ccm_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // Fields from bit 0 up: a_re, a_im, b_re, b_im.
  input  logic [ccm_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Fields from bit 0 up: magnitude.
  output logic [ccm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import ccm_pkg::*;

  ccm_cmd_t cmd;
  ccm_sts_t sts;

  ccm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ccm_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
